>>> rtl/core/assert_macros.svh
// shared assertion macros for the rtl/core checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define EWE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define EWE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that stays armed through reset
`define EWE_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/ewe_pkg.sv
package ewe_pkg;

    // quotient bits per divide and bits retired per divider stage
    localparam int QUO_BITS = 32;
    localparam int DIV_STEP = 2;
    // input register, one stage per step group, output saturation register
    localparam int DIV_LAT  = QUO_BITS / DIV_STEP + 2;

    localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
    // any magnitude at or above 2^31 saturates
    localparam logic [63:0] OVF_MAG = 64'h0000_0001_0000_0000;

    localparam logic [17:0] HEAT_RATIO_RESET = 18'd91750;

    // wave family codes
    localparam logic [1:0] WAVE_SLOW    = 2'd0;
    localparam logic [1:0] WAVE_ENTROPY = 2'd1;
    localparam logic [1:0] WAVE_FAST    = 2'd2;

    function automatic logic [31:0] abs_val(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // apply sign to a magnitude and clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic big;
        big = |mag[63:31];
        if (neg) begin
            return big ? MIN_VAL : (~mag[31:0] + 32'd1);
        end
        return big ? MAX_VAL : mag[31:0];
    endfunction

endpackage

>>> rtl/core/ewe_div.sv
module ewe_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_den,
    output logic signed [31:0] o_quo
);

    localparam int NW   = 33 + FRAC_BITS;
    localparam int QB   = ewe_pkg::QUO_BITS;
    localparam int STEP = ewe_pkg::DIV_STEP;
    localparam int NSTG = QB / STEP;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QB-1:0] quo;
        logic [31:0]   den;
        logic          neg;
        logic          ovf;
        logic          zero;
    } t_dstage;

    t_dstage            r_stg [NSTG+1];
    logic signed [31:0] r_quo;

    logic [31:0]   w_mag;
    logic [NW-1:0] w_n;
    logic          w_ovf;

    // rounded numerator: |num| * 2^frac + den/2
    assign w_mag = ewe_pkg::abs_val(i_num);
    assign w_n   = (NW'(w_mag) << FRAC_BITS) + NW'(i_den >> 1);
    // quotient would need more than 32 bits (also catches a zero divisor)
    assign w_ovf = 64'(w_n) >= {i_den, 32'd0};

    always_ff @(posedge i_clk) begin
        r_stg[0].rem  <= w_n;
        r_stg[0].quo  <= '0;
        r_stg[0].den  <= i_den;
        r_stg[0].neg  <= i_num[31];
        r_stg[0].ovf  <= w_ovf;
        r_stg[0].zero <= (i_num == 32'sd0);
    end

    for (genvar j = 0; j < NSTG; j++) begin : g_stg
        t_dstage w_nx;

        always_comb begin
            logic [63:0] v_dsh;
            w_nx = r_stg[j];
            for (int b = 0; b < STEP; b++) begin
                v_dsh = 64'(w_nx.den) << (QB - 1 - j * STEP - b);
                if (64'(w_nx.rem) >= v_dsh) begin
                    w_nx.rem = NW'(64'(w_nx.rem) - v_dsh);
                    w_nx.quo = {w_nx.quo[QB-2:0], 1'b1};
                end else begin
                    w_nx.quo = {w_nx.quo[QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_stg[j+1] <= w_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_stg[NSTG].zero) begin
            r_quo <= '0;
        end else begin
            r_quo <= ewe_pkg::sat_mag(r_stg[NSTG].ovf ? ewe_pkg::OVF_MAG
                                                      : 64'(r_stg[NSTG].quo),
                                      r_stg[NSTG].neg);
        end
    end

    assign o_quo = r_quo;

endmodule

>>> rtl/core/euler_wave_eigensystem.sv
// results: the first of three results strobes after the input register, both divider passes,
//   the multiplier registers and the output register; the other two follow back to back
// spacing: a new state can enter before earlier ones are through; busy, high after each
//   accepted state, spaces states for the three results on the single output port
// reset: synchronous active low, clears pipeline valids, output strobe and busy, and
//   loads heat_ratio with 1.4; the receiver cannot stall, so nothing ever backs up
module euler_wave_eigensystem #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [30:0] i_density,
    input  logic signed [31:0] i_velocity,
    input  logic        [30:0] i_sound_speed,
    input  logic signed [31:0] i_total_enthalpy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [17:0] i_cfg_heat_ratio,
    output logic               o_strobe,
    output logic        [1:0]  o_wave_index,
    output logic signed [31:0] o_eigenvalue,
    output logic signed [31:0] o_right_mass,
    output logic signed [31:0] o_right_momentum,
    output logic signed [31:0] o_right_energy,
    output logic signed [31:0] o_left_first,
    output logic signed [31:0] o_left_second,
    output logic signed [31:0] o_left_third,
    output logic               o_last_wave
);

    localparam int LD = ewe_pkg::DIV_LAT;
    // valid shift: input register, two divider passes, two multiplier stages
    localparam int VL = 2 * LD + 3;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic [1:0] GAP = 2'd2;

    // divider slots: first pass on the input state, second pass on its quotients
    localparam int D_GM_A   = 0;
    localparam int D_RHO_A  = 1;
    localparam int D_U_A    = 2;
    localparam int D_GM_2R  = 3;
    localparam int D_U_2R   = 4;
    localparam int D_ONE_2R = 5;
    localparam int D_T      = 6;
    localparam int D_C      = 7;
    localparam int NDIV     = 8;

    // multiplier lanes
    localparam int M_RH  = 0;
    localparam int M_RMM = 1;
    localparam int M_RMP = 2;
    localparam int M_RU  = 3;
    localparam int M_CK  = 4;
    localparam int M_CU  = 5;
    localparam int M_TK  = 6;
    localparam int M_TU  = 7;
    localparam int M_K   = 8;
    localparam int NMUL  = 9;

    typedef struct packed {
        logic        [30:0] rho;
        logic signed [31:0] u;
        logic        [30:0] a;
        logic signed [31:0] h;
    } t_side_a;

    typedef struct packed {
        logic        [30:0] rho;
        logic signed [31:0] u;
        logic signed [31:0] h;
        logic        [30:0] a;
        logic signed [31:0] ra;
        logic signed [31:0] ua;
        logic signed [31:0] u2r;
        logic signed [31:0] i2r;
    } t_side_b;

    typedef struct packed {
        logic signed [31:0] u;
        logic        [30:0] a;
        logic signed [31:0] ra;
        logic signed [31:0] u2r;
        logic signed [31:0] i2r;
        logic signed [31:0] c;
        logic signed [31:0] t;
        logic signed [31:0] k;
    } t_side_c;

    typedef struct packed {
        logic signed [31:0] eig;
        logic signed [31:0] r0;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] l0;
        logic signed [31:0] l1;
        logic signed [31:0] l2;
    } t_result;

    function automatic logic signed [31:0] sadd(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [32:0] s;
        s = {x[31], x} + {y[31], y};
        if (s[32] != s[31]) begin
            return s[32] ? ewe_pkg::MIN_VAL : ewe_pkg::MAX_VAL;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [32:0] s;
        s = {x[31], x} - {y[31], y};
        if (s[32] != s[31]) begin
            return s[32] ? ewe_pkg::MIN_VAL : ewe_pkg::MAX_VAL;
        end
        return s[31:0];
    endfunction

    // configuration and handshake control
    logic [17:0]   r_heat;
    logic [1:0]    r_gap;
    logic [VL-1:0] r_vsh;
    logic          w_acc;
    logic signed [31:0] w_gm1;

    // data path
    t_side_a            r_s0;
    t_side_a            r_la [LD];
    t_side_b            r_lb [LD];
    logic signed [31:0] r_lk [LD-2];
    t_side_c            r_lc [2];
    logic signed [31:0] w_dnum [NDIV];
    logic        [31:0] w_dden [NDIV];
    logic signed [31:0] w_dquo [NDIV];
    logic signed [31:0] w_mx [NMUL];
    logic signed [31:0] w_my [NMUL];
    logic        [63:0] r_mm [NMUL];
    logic               r_mn [NMUL];
    logic signed [31:0] r_mp [NMUL];

    // result serializer
    t_result     r_out;
    t_result     r_hold1;
    t_result     r_hold2;
    logic [1:0]  r_emit;
    logic        r_strobe;
    logic [1:0]  r_widx;
    logic        r_last;
    t_result     w_res0;
    t_result     w_res1;
    t_result     w_res2;
    t_side_a     w_pa;
    t_side_b     w_pb;
    t_side_c     w_pc;
    logic signed [31:0] w_ncu;
    logic        w_done;

    // ---------------------------------------------------------------
    // input handshake: a state is taken when busy is low, then busy
    // is held high by the gap counter so the serializer never overlaps
    // ---------------------------------------------------------------
    assign w_acc = start & ~busy;
    assign busy  = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
            r_vsh <= '0;
        end else begin
            r_vsh <= {r_vsh[VL-2:0], w_acc};
            if (w_acc) begin
                r_gap <= GAP;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
        end
    end

    // gamma register, writable at any time the channel offers a transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat <= ewe_pkg::HEAT_RATIO_RESET;
        end else if (i_cfg_valid) begin
            r_heat <= i_cfg_heat_ratio;
        end
    end

    // g-1 as a signed difference
    assign w_gm1 = $signed({14'd0, r_heat}) - ONE;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s0.rho <= i_density;
            r_s0.u   <= i_velocity;
            r_s0.a   <= i_sound_speed;
            r_s0.h   <= i_total_enthalpy;
        end
    end

    // ---------------------------------------------------------------
    // divider bank: six quotients of the input state, then the two
    // second-level quotients t and c once the first pass is done
    // ---------------------------------------------------------------
    assign w_pa = r_la[LD-1];

    always_comb begin
        w_dnum[D_GM_A]   = w_gm1;
        w_dden[D_GM_A]   = {1'b0, r_s0.a};
        w_dnum[D_RHO_A]  = {1'b0, r_s0.rho};
        w_dden[D_RHO_A]  = {1'b0, r_s0.a};
        w_dnum[D_U_A]    = r_s0.u;
        w_dden[D_U_A]    = {1'b0, r_s0.a};
        w_dnum[D_GM_2R]  = w_gm1;
        w_dden[D_GM_2R]  = {r_s0.rho, 1'b0};
        w_dnum[D_U_2R]   = r_s0.u;
        w_dden[D_U_2R]   = {r_s0.rho, 1'b0};
        w_dnum[D_ONE_2R] = ONE;
        w_dden[D_ONE_2R] = {r_s0.rho, 1'b0};
        // second pass, aligned with the delayed copy of the state
        w_dnum[D_T]      = w_dquo[D_GM_A];
        w_dden[D_T]      = {1'b0, w_pa.a};
        w_dnum[D_C]      = w_dquo[D_GM_2R];
        w_dden[D_C]      = {1'b0, w_pa.a};
    end

    for (genvar d = 0; d < NDIV; d++) begin : g_div
        ewe_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_num (w_dnum[d]),
            .i_den (w_dden[d]),
            .o_quo (w_dquo[d])
        );
    end

    // side data rides along with the dividers
    always_ff @(posedge i_clk) begin
        r_la[0] <= r_s0;
        for (int i = 1; i < LD; i++) begin
            r_la[i] <= r_la[i-1];
        end

        r_lb[0].rho <= w_pa.rho;
        r_lb[0].u   <= w_pa.u;
        r_lb[0].h   <= w_pa.h;
        r_lb[0].a   <= w_pa.a;
        r_lb[0].ra  <= w_dquo[D_RHO_A];
        r_lb[0].ua  <= w_dquo[D_U_A];
        r_lb[0].u2r <= w_dquo[D_U_2R];
        r_lb[0].i2r <= w_dquo[D_ONE_2R];
        for (int i = 1; i < LD; i++) begin
            r_lb[i] <= r_lb[i-1];
        end

        // k, computed through the multiplier registers during the second pass, waits for t and c
        r_lk[0] <= r_mp[M_K];
        for (int i = 1; i < LD - 2; i++) begin
            r_lk[i] <= r_lk[i-1];
        end

        r_lc[0].u   <= w_pb.u;
        r_lc[0].a   <= w_pb.a;
        r_lc[0].ra  <= w_pb.ra;
        r_lc[0].u2r <= w_pb.u2r;
        r_lc[0].i2r <= w_pb.i2r;
        r_lc[0].c   <= w_dquo[D_C];
        r_lc[0].t   <= w_dquo[D_T];
        r_lc[0].k   <= r_lk[LD-3];
        r_lc[1]     <= r_lc[0];
    end

    // ---------------------------------------------------------------
    // multiplier lanes: magnitude product, then round half away from
    // zero and saturate; k = u*u/2 uses one more shift bit
    // ---------------------------------------------------------------
    assign w_pb = r_lb[LD-1];

    always_comb begin
        w_mx[M_RH]  = w_pb.ra;
        w_my[M_RH]  = w_pb.h;
        w_mx[M_RMM] = {1'b0, w_pb.rho};
        w_my[M_RMM] = ssub(w_pb.ua, ONE);
        w_mx[M_RMP] = {1'b0, w_pb.rho};
        w_my[M_RMP] = sadd(w_pb.ua, ONE);
        w_mx[M_RU]  = {1'b0, w_pb.rho};
        w_my[M_RU]  = w_pb.u;
        w_mx[M_CK]  = w_dquo[D_C];
        w_my[M_CK]  = r_lk[LD-3];
        w_mx[M_CU]  = w_dquo[D_C];
        w_my[M_CU]  = w_pb.u;
        w_mx[M_TK]  = w_dquo[D_T];
        w_my[M_TK]  = r_lk[LD-3];
        w_mx[M_TU]  = w_dquo[D_T];
        w_my[M_TU]  = w_pb.u;
        // runs during the second divider pass
        w_mx[M_K]   = w_pa.u;
        w_my[M_K]   = w_pa.u;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NMUL; j++) begin
            r_mm[j] <= 64'(ewe_pkg::abs_val(w_mx[j])) * 64'(ewe_pkg::abs_val(w_my[j]));
            r_mn[j] <= w_mx[j][31] ^ w_my[j][31];
            if (j == M_K) begin
                r_mp[j] <= ewe_pkg::sat_mag((r_mm[j] + (64'd1 << FRAC_BITS))
                                            >> (FRAC_BITS + 1), r_mn[j]);
            end else begin
                r_mp[j] <= ewe_pkg::sat_mag((r_mm[j] + (64'd1 << (FRAC_BITS - 1)))
                                            >> FRAC_BITS, r_mn[j]);
            end
        end
    end

    // ---------------------------------------------------------------
    // final sums for all three wave families
    // ---------------------------------------------------------------
    assign w_pc   = r_lc[1];
    assign w_done = r_vsh[VL-1];
    assign w_ncu  = ssub(32'sd0, r_mp[M_CU]);

    always_comb begin
        // u-a family
        w_res0.eig = ssub(w_pc.u, {1'b0, w_pc.a});
        w_res0.r0  = w_pc.ra;
        w_res0.r1  = r_mp[M_RMM];
        w_res0.r2  = ssub(r_mp[M_RH], r_mp[M_RU]);
        w_res0.l0  = sadd(r_mp[M_CK], w_pc.u2r);
        w_res0.l1  = ssub(w_ncu, w_pc.i2r);
        w_res0.l2  = w_pc.c;
        // entropy wave
        w_res1.eig = w_pc.u;
        w_res1.r0  = ONE;
        w_res1.r1  = w_pc.u;
        w_res1.r2  = w_pc.k;
        w_res1.l0  = ssub(ONE, r_mp[M_TK]);
        w_res1.l1  = r_mp[M_TU];
        w_res1.l2  = ssub(32'sd0, w_pc.t);
        // u+a family
        w_res2.eig = sadd(w_pc.u, {1'b0, w_pc.a});
        w_res2.r0  = w_pc.ra;
        w_res2.r1  = r_mp[M_RMP];
        w_res2.r2  = sadd(r_mp[M_RH], r_mp[M_RU]);
        w_res2.l0  = ssub(r_mp[M_CK], w_pc.u2r);
        w_res2.l1  = sadd(w_ncu, w_pc.i2r);
        w_res2.l2  = w_pc.c;
    end

    // ---------------------------------------------------------------
    // serializer: first family goes straight out, the other two wait
    // in hold registers and follow in consecutive cycles
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_emit   <= 2'd0;
        end else if (w_done) begin
            r_strobe <= 1'b1;
            r_emit   <= 2'd2;
        end else if (r_emit != 2'd0) begin
            r_strobe <= 1'b1;
            r_emit   <= r_emit - 2'd1;
        end else begin
            r_strobe <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out   <= w_res0;
            r_widx  <= ewe_pkg::WAVE_SLOW;
            r_last  <= 1'b0;
            r_hold1 <= w_res1;
            r_hold2 <= w_res2;
        end else if (r_emit == 2'd2) begin
            r_out  <= r_hold1;
            r_widx <= ewe_pkg::WAVE_ENTROPY;
            r_last <= 1'b0;
        end else if (r_emit == 2'd1) begin
            r_out  <= r_hold2;
            r_widx <= ewe_pkg::WAVE_FAST;
            r_last <= 1'b1;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_wave_index     = r_widx;
    assign o_eigenvalue     = r_out.eig;
    assign o_right_mass     = r_out.r0;
    assign o_right_momentum = r_out.r1;
    assign o_right_energy   = r_out.r2;
    assign o_left_first     = r_out.l0;
    assign o_left_second    = r_out.l1;
    assign o_left_third     = r_out.l2;
    assign o_last_wave      = r_last;

endmodule

>>> rtl/core/ewe_checker.sv
`include "assert_macros.svh"

module ewe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [1:0] o_wave_index,
    input logic       o_last_wave
);

    `EWE_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `EWE_ASSERT_NEXT(a_slow_then_entropy, i_clk, i_rst_n, o_strobe && o_wave_index == ewe_pkg::WAVE_SLOW, o_strobe && o_wave_index == ewe_pkg::WAVE_ENTROPY)
    `EWE_ASSERT_NEXT(a_entropy_then_fast, i_clk, i_rst_n, o_strobe && o_wave_index == ewe_pkg::WAVE_ENTROPY, o_strobe && o_wave_index == ewe_pkg::WAVE_FAST)
    `EWE_ASSERT_NOW(a_last_on_fast, i_clk, i_rst_n, o_strobe, o_last_wave == (o_wave_index == ewe_pkg::WAVE_FAST))
    `EWE_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !o_strobe && !busy)

endmodule

bind euler_wave_eigensystem ewe_checker u_ewe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_wave_index (o_wave_index),
    .o_last_wave  (o_last_wave)
);
